// File: rtl/core/tdls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdls_pkg;

    localparam int MAX_LINE = 64;
    localparam int IDX_W    = $clog2(MAX_LINE);
    localparam int CNT_W    = IDX_W + 1;
    localparam int Q_W      = 32;
    localparam int DEN_W    = 34;
    localparam int RND_W    = 48;

    localparam logic [1:0] REG_OFF_COEF    = 2'd0;
    localparam logic [1:0] REG_DIAG_BASE   = 2'd1;
    localparam logic [1:0] REG_LINE_LENGTH = 2'd2;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PIV_0,
        S_PIV_DIV,
        S_PIV_E,
        S_PIV_T,
        S_FW_RD0,
        S_FW_LD0,
        S_FW_RD,
        S_FW_MUL,
        S_FW_ADD,
        S_LS_RD,
        S_LS_MUL,
        S_LS_WR,
        S_BW_RD,
        S_BW_S,
        S_BW_WR,
        S_EM_RD,
        S_EM_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic             nonpos;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic           busy;
        logic [Q_W-1:0] quo;
    } t_div_rsp;

    // Product rounded to Q16.16, to nearest with ties upwards on the magnitude.
    function automatic logic [RND_W-1:0] f_rnd(input logic [2*Q_W-1:0] prod);
        logic [2*Q_W-1:0] s;
        s = prod + 64'd32768;
        return s[2*Q_W-1:16];
    endfunction

    function automatic logic [Q_W-1:0] f_sat_u(input logic [2*Q_W-1:0] prod);
        logic [RND_W-1:0] m;
        m = f_rnd(prod);
        return (m[RND_W-1:Q_W] != '0) ? {Q_W{1'b1}} : m[Q_W-1:0];
    endfunction

    // Rounded signed product from a magnitude product and its sign, saturated.
    function automatic logic signed [Q_W-1:0] f_sat_sq(input logic neg,
                                                      input logic [2*Q_W-1:0] prod);
        logic [RND_W-1:0] m;
        logic [Q_W-1:0]   r;
        m = f_rnd(prod);
        if (!neg) begin
            if (m > 48'h0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else r = m[Q_W-1:0];
        end else begin
            if (m > 48'h0000_8000_0000) r = 32'h8000_0000;
            else r = 32'd0 - m[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] f_sat_add(input logic signed [Q_W-1:0] a,
                                                       input logic signed [Q_W-1:0] b);
        logic [Q_W:0] s;
        logic [Q_W-1:0] r;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) r = s[Q_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else r = s[Q_W-1:0];
        return r;
    endfunction

    function automatic logic [Q_W-1:0] f_abs(input logic signed [Q_W-1:0] x);
        return x[Q_W-1] ? (32'd0 - x) : x;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tdls_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tdls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tdls_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module tdls_mul
    import tdls_pkg::*;
(
    input  wire                  i_clk,
    input  wire [Q_W-1:0]        i_a,
    input  wire [Q_W-1:0]        i_b,
    input  wire                  i_neg,
    output logic [2*Q_W-1:0]     o_prod,
    output logic                 o_neg
);

    logic [2*Q_W-1:0] r_prod;
    logic             r_neg;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
        r_neg  <= i_neg;
    end

    assign o_prod = r_prod;
    assign o_neg  = r_neg;

endmodule

`default_nettype wire

// File: rtl/core/tdls_div.sv
`timescale 1ns / 1ps
`default_nettype none

module tdls_div
    import tdls_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_rsp       o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [5:0]       r_cnt, n_cnt;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_div, n_div;
    logic [Q_W-1:0]   r_q, n_q;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    // Restoring division of 2^32 + den/2 by den, one quotient bit a cycle.
    always_comb begin
        w_sh  = {r_rem[DEN_W-1:0], r_quo[DEN_W-1]};
        w_ge  = w_sh >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_q    = r_q;
        if (i_req.start) begin
            if (i_req.nonpos) begin
                n_q    = {Q_W{1'b1}};
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_cnt  = 6'(DEN_W - 1);
                n_rem  = '0;
                n_div  = i_req.den;
                n_quo  = 34'h1_0000_0000 + {1'b0, i_req.den[DEN_W-1:1]};
            end
        end else if (r_busy) begin
            n_rem = w_ge ? (w_sh - {1'b0, r_div}) : w_sh;
            n_quo = {r_quo[DEN_W-2:0], w_ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_q    = (n_quo[DEN_W-1:Q_W] != '0) ? {Q_W{1'b1}} : n_quo[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_q;

endmodule

`default_nettype wire

// File: rtl/core/tridiagonal_diffusion_line_solver_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Implicit diffusion-decay line solver (Thomas scheme) in Q16.16. Samples are
// taken one per request until line_length of them (clamped to 2..64) are held;
// the block then drops o_ready, computes the reciprocal pivots with a shared
// restoring divider, runs the forward sweep and back substitution through one
// shared 32x32 multiplier and emits the solved samples in index order, holding
// each one while the output is stalled. The final result may still wait in the
// output register while the next line loads.
module tridiagonal_diffusion_line_solver_core
    import tdls_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_en,
    input  wire [1:0]             i_cfg_idx,
    input  wire [Q_W-1:0]         i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire signed [Q_W-1:0]  i_density_in,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic signed [Q_W-1:0] o_density_out,
    output logic                  o_last_out
);

    t_state r_state, n_state;

    logic [Q_W-1:0]   r_off_coef, r_diag_base;
    logic [6:0]       r_line_length;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] r_idx;
    logic signed [Q_W-1:0] r_prev;
    logic             r_ov;
    logic signed [Q_W-1:0] r_dout;
    logic             r_last;

    logic [CNT_W-1:0] w_n_eff;
    logic [IDX_W-1:0] w_last_idx;
    logic             w_at_last;
    logic             w_in_acc;
    logic             w_line_done;
    logic             w_out_load;

    logic             w_ls_we, w_rp_we, w_ef_we;
    logic [IDX_W-1:0] w_ls_waddr;
    logic [Q_W-1:0]   w_ls_wdata;
    logic [Q_W-1:0]   w_ls_rd, w_rp_rd, w_ef_rd;

    logic [Q_W-1:0]   w_mul_a, w_mul_b;
    logic             w_mul_neg;
    logic [2*Q_W-1:0] w_prod;
    logic             w_prod_neg;
    logic signed [Q_W-1:0] w_sq;
    logic [Q_W-1:0]   w_e;
    logic signed [Q_W-1:0] w_s;
    logic signed [Q_W-1:0] w_fw_d;

    logic [DEN_W-1:0] w_diag;
    logic [RND_W-1:0] w_t;
    logic [RND_W+1:0] w_den;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_coef    <= '0;
            r_diag_base   <= 32'h0001_0000;
            r_line_length <= 7'd64;
        end else if (i_cfg_en) begin
            unique case (i_cfg_idx)
                REG_OFF_COEF:    r_off_coef    <= i_cfg_data;
                REG_DIAG_BASE:   r_diag_base   <= i_cfg_data;
                REG_LINE_LENGTH: r_line_length <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_line_length < 7'd2) w_n_eff = 7'd2;
        else if (r_line_length > 7'(MAX_LINE)) w_n_eff = 7'(MAX_LINE);
        else w_n_eff = r_line_length;
    end

    assign w_last_idx  = IDX_W'(r_n - 7'd1);
    assign w_at_last   = r_idx == w_last_idx;
    assign w_in_acc    = i_valid && o_ready;
    assign w_line_done = (r_cnt + 7'd1) >= w_n_eff;
    assign w_out_load  = (r_state == S_EM_OUT) && (!r_ov || i_ready);

    // Shared arithmetic.
    assign w_sq   = f_sat_sq(w_prod_neg, w_prod);
    assign w_e    = f_sat_u(w_prod);
    assign w_s    = f_sat_add(w_ls_rd, w_sq);
    assign w_fw_d = f_sat_add(w_ls_rd, w_sq);

    // End diagonals carry one off_coef, inner ones two.
    always_comb begin
        w_diag = {2'b0, r_diag_base} + {2'b0, r_off_coef};
        if (r_idx != '0 && !w_at_last) begin
            w_diag = w_diag + {2'b0, r_off_coef};
        end
        w_t   = (r_state == S_PIV_T) ? f_rnd(w_prod) : '0;
        w_den = {16'd0, w_diag} - {2'b0, w_t};
    end

    assign w_div_req.start  = (r_state == S_PIV_0) || (r_state == S_PIV_T);
    assign w_div_req.nonpos = w_den[RND_W+1] || (w_den == '0);
    assign w_div_req.den    = w_den[DEN_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:    if (w_in_acc && w_line_done) n_state = S_PIV_0;
            S_PIV_0:   n_state = S_PIV_DIV;
            S_PIV_DIV: begin
                if (w_div_rsp.done) n_state = w_at_last ? S_FW_RD0 : S_PIV_E;
            end
            S_PIV_E:   n_state = S_PIV_T;
            S_PIV_T:   n_state = S_PIV_DIV;
            S_FW_RD0:  n_state = S_FW_LD0;
            S_FW_LD0:  n_state = S_FW_RD;
            S_FW_RD:   n_state = S_FW_MUL;
            S_FW_MUL:  n_state = S_FW_ADD;
            S_FW_ADD:  n_state = w_at_last ? S_LS_RD : S_FW_RD;
            S_LS_RD:   n_state = S_LS_MUL;
            S_LS_MUL:  n_state = S_LS_WR;
            S_LS_WR:   n_state = S_BW_RD;
            S_BW_RD:   n_state = S_BW_S;
            S_BW_S:    n_state = S_BW_WR;
            S_BW_WR:   n_state = (r_idx == '0) ? S_EM_RD : S_BW_RD;
            S_EM_RD:   n_state = S_EM_OUT;
            S_EM_OUT:  begin
                if (w_out_load) n_state = w_at_last ? S_LOAD : S_EM_RD;
            end
            default:   n_state = S_LOAD;
        endcase
    end

    // Datapath control.
    always_comb begin
        o_ready    = r_state == S_LOAD;
        w_ls_we    = 1'b0;
        w_ls_waddr = r_idx;
        w_ls_wdata = w_sq;
        w_rp_we    = 1'b0;
        w_ef_we    = 1'b0;
        w_mul_a    = f_abs(r_prev);
        w_mul_b    = r_off_coef;
        w_mul_neg  = r_prev[Q_W-1];
        unique case (r_state)
            S_LOAD: begin
                w_ls_we    = w_in_acc;
                w_ls_waddr = r_cnt[IDX_W-1:0];
                w_ls_wdata = i_density_in;
            end
            S_PIV_DIV: begin
                w_rp_we   = w_div_rsp.done;
                w_mul_a   = r_off_coef;
                w_mul_b   = w_div_rsp.quo;
                w_mul_neg = 1'b0;
            end
            S_PIV_E: begin
                w_ef_we   = 1'b1;
                w_mul_a   = w_e;
                w_mul_b   = r_off_coef;
                w_mul_neg = 1'b0;
            end
            S_FW_MUL: w_mul_b = w_ef_rd;
            S_FW_ADD: begin
                w_ls_we    = 1'b1;
                w_ls_wdata = w_fw_d;
            end
            S_LS_MUL: w_mul_b = w_rp_rd;
            S_LS_WR:  w_ls_we = 1'b1;
            S_BW_S: begin
                w_mul_a   = f_abs(w_s);
                w_mul_b   = w_rp_rd;
                w_mul_neg = w_s[Q_W-1];
            end
            S_BW_WR:  w_ls_we = 1'b1;
            default: ;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_n     <= 7'(MAX_LINE);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_line_done) begin
                            r_cnt <= '0;
                            r_idx <= '0;
                            r_n   <= w_n_eff;
                        end else begin
                            r_cnt <= r_cnt + 7'd1;
                        end
                    end
                end
                S_PIV_DIV: begin
                    if (w_div_rsp.done) r_idx <= w_at_last ? '0 : r_idx + 6'd1;
                end
                S_FW_LD0: r_idx <= 6'd1;
                S_FW_ADD: if (!w_at_last) r_idx <= r_idx + 6'd1;
                S_LS_WR:  r_idx <= r_idx - 6'd1;
                S_BW_WR:  if (r_idx != '0) r_idx <= r_idx - 6'd1;
                S_EM_OUT: begin
                    if (w_out_load) r_idx <= w_at_last ? '0 : r_idx + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // Carried sample between sweep steps, and the output sample register.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_FW_LD0: r_prev <= w_ls_rd;
            S_FW_ADD: r_prev <= w_fw_d;
            S_LS_WR,
            S_BW_WR:  r_prev <= w_sq;
            default: ;
        endcase
        if (w_out_load) begin
            r_dout <= w_ls_rd;
            r_last <= w_at_last;
        end
    end

    assign o_valid       = r_ov;
    assign o_density_out = r_dout;
    assign o_last_out    = r_last;

    tdls_ram #(.WIDTH(Q_W), .DEPTH(MAX_LINE)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ls_we),
        .i_waddr (w_ls_waddr),
        .i_wdata (w_ls_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_ls_rd)
    );

    tdls_ram #(.WIDTH(Q_W), .DEPTH(MAX_LINE)) u_recip_pivot (
        .i_clk   (i_clk),
        .i_we    (w_rp_we),
        .i_waddr (r_idx),
        .i_wdata (w_div_rsp.quo),
        .i_raddr (r_idx),
        .o_rdata (w_rp_rd)
    );

    tdls_ram #(.WIDTH(Q_W), .DEPTH(MAX_LINE)) u_elim_factor (
        .i_clk   (i_clk),
        .i_we    (w_ef_we),
        .i_waddr (r_idx - 6'd1),
        .i_wdata (w_e),
        .i_raddr (r_idx - 6'd1),
        .o_rdata (w_ef_rd)
    );

    tdls_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .i_neg  (w_mul_neg),
        .o_prod (w_prod),
        .o_neg  (w_prod_neg)
    );

    tdls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < 7'(MAX_LINE))
        else $error("load count out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> ({1'b0, r_idx} < r_n))
        else $error("element index beyond line length");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !w_div_rsp.busy)
        else $error("divider busy while loading");

endmodule

`default_nettype wire
